// ===== sv/tcw_pkg.sv =====
// shared types, constants and codes for the text console character writer
// no dependencies; imported by every other file of the block
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // field widths fixed by the interface
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;

  // column phase within a tab stop
  localparam int PHASE_W = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;

  // command queue between front and engine
  localparam int QUEUE_DEPTH = 2;

  // request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // control characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // cell contents after reset: light grey blank
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

  // configuration register indexes
  localparam logic CFG_BACKGROUND = 1'b0;
  localparam logic CFG_FOREGROUND = 1'b1;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [7:0]        char_code;
    logic [ADDR_W-1:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [ADDR_W-1:0] cursor_linear;
    logic [CELL_W-1:0] cell_value;
  } result_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_DRAIN,
    S_FILL
  } state_t;

endpackage

`default_nettype wire

// ===== sv/tcw_ifs.sv =====
// valid/ready channel interfaces for request words and result words
// depends on tcw_pkg for field widths
`default_nettype none

interface tcw_in_if
  import tcw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [7:0]        char_code;
  logic [ADDR_W-1:0] cell_index;

  modport source (output valid, req_type, char_code, cell_index, input ready);
  modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcw_out_if
  import tcw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;
  logic [ADDR_W-1:0] cursor_linear;
  logic [CELL_W-1:0] cell_value;

  modport source (output valid, cursor_column, cursor_row, cursor_linear, cell_value,
                  input ready);
  modport sink   (input valid, cursor_column, cursor_row, cursor_linear, cell_value,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/text_console_char_writer_top.sv =====
// top level of the text console character writer
// depends on tcw_pkg, tcw_ifs, tcw_front, tcw_queue and tcw_engine
`default_nettype none

// Character-cell text console, 80 columns by 25 rows of 16-bit cells.
// in_ch carries request words (put character, clear screen, read cell); out_ch
// returns one result word per request: cursor column, row, linear position and,
// for a read, the cell value (0 otherwise).
// cfg_we / cfg_index / cfg_wdata write the background (index 0) and foreground
// (index 1) colour nibbles; write them only while no request is in flight.
// Cursor moves and printable characters update the result register directly; a
// read goes through a read state for the registered memory port. A clear writes
// every cell with a blank, one cell written per cycle. Any put that scrolls makes
// 1920 row copies through the single write port, a drain write, then 80 blank
// writes.
// Throughput is one request per cycle for cursor moves and prints while the
// receiver takes each result; a clear or scroll holds the engine for its sweep
// through the one-cell-per-cycle memory port. A two-word queue lets the input
// side run ahead of the engine. After reset the engine fills the screen with
// 0x0720 blanks; requests queue but are not executed until that pass ends.
// A stalled receiver holds the result register; the engine waits for it to
// drain before it takes the next command from the queue.
module text_console_char_writer_top
  import tcw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  tcw_in_if.sink          in_ch,
  tcw_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_wdata
);

  // colour registers
  logic [3:0] bg_r, bg_nxt;
  logic [3:0] fg_r, fg_nxt;

  // queue hookup
  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  always_comb begin
    bg_nxt = bg_r;
    fg_nxt = fg_r;
    if (cfg_we) begin
      if (cfg_index == CFG_BACKGROUND) begin
        bg_nxt = cfg_wdata;
      end else begin
        fg_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r <= 4'd0;
      fg_r <= 4'd7;
    end else begin
      bg_r <= bg_nxt;
      fg_r <= fg_nxt;
    end
  end

  // decode request words into commands
  tcw_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // decouple decoder from the long-running engine
  tcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // cursor, cell memory and result register
  tcw_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .attr    ({bg_r, fg_r}),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== sv/tcw_front.sv =====
// request front end: accepts request words and decodes them into commands
// depends on tcw_pkg and tcw_in_if
`default_nettype none

module tcw_front
  import tcw_pkg::*;
(
  tcw_in_if.sink in_ch,
  input  wire logic q_full,
  output logic      q_push,
  output cmd_t      q_data
);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_data.char_code  = in_ch.char_code;
    q_data.cell_index = in_ch.cell_index;
    unique case (in_ch.req_type)
      REQ_PUT: begin
        unique case (in_ch.char_code)
          CH_BS:   q_data.op = OP_BS;
          CH_TAB:  q_data.op = OP_TAB;
          CH_CR:   q_data.op = OP_CR;
          CH_LF:   q_data.op = OP_LF;
          default: q_data.op = OP_PRINT;
        endcase
      end
      REQ_CLEAR: q_data.op = OP_CLEAR;
      REQ_READ:  q_data.op = OP_READ;
      default:   q_data.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/tcw_queue.sv =====
// short command fifo between the decoder and the screen engine
// depends on tcw_pkg for the command type and depth
`default_nettype none

module tcw_queue
  import tcw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tcw_engine.sv =====
// screen engine: cursor, cell memory, scroll and fill sweeps, result register
// depends on tcw_pkg and tcw_out_if
`default_nettype none

module tcw_engine
  import tcw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] attr,
  input  wire logic       q_valid,
  input  cmd_t            q_head,
  output logic            q_pop,
  tcw_out_if.source       out_ch
);

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] FIRST_SRC = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW0 = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [7:0]        COLS_8    = 8'(COLUMNS);
  localparam logic [ROW_W:0]    ROWS_6    = (ROW_W + 1)'(ROWS);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              cp_vld_r, cp_vld_nxt;
  logic [ADDR_W-1:0] cp_addr_r, cp_addr_nxt;
  logic              oob_r, oob_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PHASE_W-1:0] ph_r, ph_nxt;
  logic              ov_r, ov_nxt;
  result_t           res_r, res_nxt;

  logic [CELL_W-1:0] blank;
  logic [ADDR_W-1:0] lin_cur;
  logic [ADDR_W-1:0] lin_new;
  logic              slot_free;

  // cursor step for one put command
  logic [7:0]         pc_col;
  logic [ROW_W:0]     pc_row;
  logic [PHASE_W-1:0] pc_ph;
  logic               pc_write;
  logic               pc_scroll;

  function automatic logic [ADDR_W-1:0] lin_pos(input logic [COL_W-1:0] c,
                                                input logic [ROW_W-1:0] r);
    return ADDR_W'(int'(r) * COLUMNS + int'(c));
  endfunction

  assign blank     = {attr, CH_SPACE};
  assign lin_cur   = lin_pos(col_r, row_r);
  assign lin_new   = lin_pos(col_nxt, row_nxt);
  assign slot_free = !ov_r || out_ch.ready;

  always_comb begin
    pc_col   = {1'b0, col_r};
    pc_row   = {1'b0, row_r};
    pc_ph    = ph_r;
    pc_write = 1'b0;
    case (q_head.op)
      OP_BS: begin
        if (col_r != '0) begin
          pc_col = {1'b0, col_r} - 8'd1;
          pc_ph  = (ph_r == '0) ? PHASE_W'(TAB_STOP - 1) : ph_r - 1'b1;
        end
      end
      OP_TAB: begin
        pc_col = {1'b0, col_r} + (8'(TAB_STOP) - 8'(ph_r));
        pc_ph  = '0;
      end
      OP_CR: begin
        pc_col = '0;
        pc_ph  = '0;
      end
      OP_LF: begin
        pc_col = '0;
        pc_row = {1'b0, row_r} + 1'b1;
        pc_ph  = '0;
      end
      default: begin
        pc_write = 1'b1;
        pc_col   = {1'b0, col_r} + 8'd1;
        pc_ph    = (ph_r == PHASE_W'(TAB_STOP - 1)) ? '0 : ph_r + 1'b1;
      end
    endcase
    if (pc_col >= COLS_8) begin
      pc_col = '0;
      pc_row = pc_row + 1'b1;
      pc_ph  = '0;
    end
    pc_scroll = (pc_row >= ROWS_6);
    if (pc_scroll) begin
      pc_row = ROWS_6 - 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    cp_vld_nxt  = 1'b0;
    cp_addr_nxt = cp_addr_r;
    oob_nxt     = oob_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    ph_nxt      = ph_r;
    ov_nxt      = ov_r && !out_ch.ready;
    res_nxt     = res_r;
    q_pop       = 1'b0;
    rd_addr     = ptr_r;
    mem_we      = 1'b0;
    mem_waddr   = ptr_r;
    mem_wdata   = blank;

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          unique case (q_head.op)
            OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              ph_nxt    = '0;
              ptr_nxt   = '0;
              state_nxt = S_FILL;
            end
            OP_READ: begin
              rd_addr   = q_head.cell_index;
              oob_nxt   = (q_head.cell_index > LAST_CELL);
              state_nxt = S_READ;
            end
            OP_NOP: begin
              ov_nxt  = 1'b1;
              res_nxt = '{col_r, row_r, lin_cur, '0};
            end
            default: begin
              col_nxt   = pc_col[COL_W-1:0];
              row_nxt   = pc_row[ROW_W-1:0];
              ph_nxt    = pc_ph;
              mem_we    = pc_write;
              mem_waddr = lin_cur;
              mem_wdata = {attr, q_head.char_code};
              if (pc_scroll) begin
                ptr_nxt   = FIRST_SRC;
                state_nxt = S_SCROLL;
              end else begin
                ov_nxt  = 1'b1;
                res_nxt = '{col_nxt, row_nxt, lin_new, '0};
              end
            end
          endcase
        end
      end
      S_READ: begin
        ov_nxt    = 1'b1;
        res_nxt   = '{col_r, row_r, lin_cur, (oob_r ? '0 : rd_data_r)};
        state_nxt = S_IDLE;
      end
      S_SCROLL: begin
        // read one row ahead, write the word read last cycle one row up
        rd_addr     = ptr_r;
        cp_vld_nxt  = 1'b1;
        cp_addr_nxt = ptr_r - FIRST_SRC;
        mem_we      = cp_vld_r;
        mem_waddr   = cp_addr_r;
        mem_wdata   = rd_data_r;
        ptr_nxt     = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = cp_addr_r;
        mem_wdata = rd_data_r;
        ptr_nxt   = LAST_ROW0;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          ov_nxt    = 1'b1;
          res_nxt   = '{col_r, row_r, lin_cur, '0};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      ptr_r    <= '0;
      cp_vld_r <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      ph_r     <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      cp_vld_r <= cp_vld_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      ph_r     <= ph_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r <= cp_addr_nxt;
    oob_r     <= oob_nxt;
    res_r     <= res_nxt;
  end

  // cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.cursor_column = res_r.cursor_column;
  assign out_ch.cursor_row    = res_r.cursor_row;
  assign out_ch.cursor_linear = res_r.cursor_linear;
  assign out_ch.cell_value    = res_r.cell_value;

endmodule

`default_nettype wire

// ===== sv/tcw_checker.sv =====
// port-level checks on the result channel of the text console
// depends on tcw_pkg; bound to text_console_char_writer_top
`default_nettype none

module tcw_checker
  import tcw_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [COL_W-1:0]  cursor_column,
  input wire logic [ROW_W-1:0]  cursor_row,
  input wire logic [ADDR_W-1:0] cursor_linear,
  input wire logic [CELL_W-1:0] cell_value
);

  // stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cursor_column) &&
      $stable(cursor_row) && $stable(cursor_linear) && $stable(cell_value))
    else $error("result word changed while stalled");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(cursor_column) < COLUMNS)
    else $error("cursor column past right edge");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(cursor_row) < ROWS)
    else $error("cursor row past bottom edge");

  a_linear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(cursor_linear) == int'(cursor_row) * COLUMNS + int'(cursor_column))
    else $error("linear cursor does not match row and column");

endmodule

bind text_console_char_writer_top tcw_checker u_tcw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .cursor_column (out_ch.cursor_column),
  .cursor_row    (out_ch.cursor_row),
  .cursor_linear (out_ch.cursor_linear),
  .cell_value    (out_ch.cell_value)
);

`default_nettype wire
